[design/lic_pkg.sv]
`default_nettype none
package lic_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = IDX_W + 1;
    localparam int KEY_W     = 32;

    // tail table read address select
    localparam logic [1:0] TSEL_MID  = 2'd0;
    localparam logic [1:0] TSEL_PREV = 2'd1;
    localparam logic [1:0] TSEL_LAST = 2'd2;

    // key store read address select
    localparam logic KSEL_TAIL = 1'b0;
    localparam logic KSEL_CUR  = 1'b1;

    typedef struct packed {
        logic       load;       // store accepted key, start search
        logic       drop;       // key past capacity
        logic       tail_rd;
        logic [1:0] tail_sel;
        logic       key_rd;
        logic       key_sel;
        logic       pred_rd;
        logic       cmp_step;   // one halving of the search range
        logic       update;     // write tail and link, bump counters
        logic       cur_load;   // chain head from tail read
        logic       cur_next;   // follow link
        logic       clear;      // end of set
    } lic_cmd_t;

    typedef struct packed {
        logic full;
        logic lo_lt_hi;
        logic chain_zero;
        logic last;
        logic final_word;
    } lic_sts_t;

endpackage
`default_nettype wire

[design/lic_if.sv]
`default_nettype none
interface lic_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] key;
    logic        last_item;

    modport source (output valid, output key, output last_item, input ready);
    modport sink   (input valid, input key, input last_item, output ready);
endinterface

interface lic_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  item_index;
    logic [31:0] chosen_key;
    logic        final_result;
    logic        overflow;

    modport source (output valid, output item_index, output chosen_key,
                    output final_result, output overflow, input ready);
    modport sink   (input valid, input item_index, input chosen_key,
                    input final_result, input overflow, output ready);
endinterface
`default_nettype wire

[design/lic_ctrl.sv]
`default_nettype none
module lic_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_last,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire lic_pkg::lic_sts_t sts,
    output lic_pkg::lic_cmd_t      cmd
);
    import lic_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SRCH = 4'd1;
    localparam logic [3:0] S_TRD  = 4'd2;
    localparam logic [3:0] S_KRD  = 4'd3;
    localparam logic [3:0] S_CMP  = 4'd4;
    localparam logic [3:0] S_PRD  = 4'd5;
    localparam logic [3:0] S_UPD  = 4'd6;
    localparam logic [3:0] S_WT   = 4'd7;
    localparam logic [3:0] S_WC   = 4'd8;
    localparam logic [3:0] S_WL   = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (sts.full)
                    begin
                        cmd.drop   = 1'b1;
                        state_next = in_last ? S_WT : S_IDLE;
                    end
                    else
                    begin
                        cmd.load   = 1'b1;
                        state_next = S_SRCH;
                    end
                end
            end
            S_SRCH:
            begin
                state_next = sts.lo_lt_hi ? S_TRD : S_PRD;
            end
            S_TRD:
            begin
                cmd.tail_rd  = 1'b1;
                cmd.tail_sel = TSEL_MID;
                state_next   = S_KRD;
            end
            S_KRD:
            begin
                cmd.key_rd  = 1'b1;
                cmd.key_sel = KSEL_TAIL;
                state_next  = S_CMP;
            end
            S_CMP:
            begin
                cmd.cmp_step = 1'b1;
                state_next   = S_SRCH;
            end
            S_PRD:
            begin
                cmd.tail_rd  = 1'b1;
                cmd.tail_sel = TSEL_PREV;
                state_next   = S_UPD;
            end
            S_UPD:
            begin
                cmd.update = 1'b1;
                state_next = sts.last ? S_WT : S_IDLE;
            end
            S_WT:
            begin
                if (sts.chain_zero)
                begin
                    cmd.clear  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.tail_rd  = 1'b1;
                    cmd.tail_sel = TSEL_LAST;
                    state_next   = S_WC;
                end
            end
            S_WC:
            begin
                cmd.cur_load = 1'b1;
                state_next   = S_WL;
            end
            S_WL:
            begin
                cmd.key_rd  = 1'b1;
                cmd.key_sel = KSEL_CUR;
                cmd.pred_rd = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (sts.final_word)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.cur_next = 1'b1;
                        state_next   = S_WL;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[design/lic_dpath.sv]
`default_nettype none
module lic_dpath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lic_pkg::lic_cmd_t cmd,
    output lic_pkg::lic_sts_t      sts,
    input  wire logic [31:0]       in_key,
    input  wire logic              in_last,
    output logic [5:0]             item_index,
    output logic [31:0]            chosen_key,
    output logic                   final_result,
    output logic                   overflow
);
    import lic_pkg::*;

    logic [KEY_W-1:0] key_mem  [MAX_ITEMS];
    logic [IDX_W-1:0] tail_mem [MAX_ITEMS];
    logic [IDX_W:0]   pred_mem [MAX_ITEMS];   // {valid, index}

    logic [CNT_W-1:0] count_reg, chain_reg, lo_reg, hi_reg;
    logic             ovf_reg, last_reg;
    logic [KEY_W-1:0] key_reg, key_q;
    logic [IDX_W-1:0] tail_q, cur_reg;
    logic [IDX_W:0]   pred_q;

    logic [CNT_W:0]   mid_sum;
    logic [CNT_W-1:0] mid;
    logic [CNT_W-1:0] lo_dec, chain_dec;
    logic [IDX_W-1:0] tail_addr, key_addr;

    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid       = mid_sum[CNT_W:1];
    assign lo_dec    = lo_reg - CNT_W'(1);
    assign chain_dec = chain_reg - CNT_W'(1);

    always_comb
    begin
        case (cmd.tail_sel)
            TSEL_MID:  tail_addr = mid[IDX_W-1:0];
            TSEL_PREV: tail_addr = lo_dec[IDX_W-1:0];
            TSEL_LAST: tail_addr = chain_dec[IDX_W-1:0];
            default:   tail_addr = mid[IDX_W-1:0];
        endcase
        key_addr = (cmd.key_sel == KSEL_CUR) ? cur_reg : tail_q;
    end

    // memories: one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_mem[count_reg[IDX_W-1:0]] <= in_key;
        end
        if (cmd.key_rd)
        begin
            key_q <= key_mem[key_addr];
        end
        if (cmd.update)
        begin
            tail_mem[lo_reg[IDX_W-1:0]]    <= count_reg[IDX_W-1:0];
            pred_mem[count_reg[IDX_W-1:0]] <= {(lo_reg != '0), tail_q};
        end
        if (cmd.tail_rd)
        begin
            tail_q <= tail_mem[tail_addr];
        end
        if (cmd.pred_rd)
        begin
            pred_q <= pred_mem[cur_reg];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg <= in_key;
        end
        if (cmd.cur_load)
        begin
            cur_reg <= tail_q;
        end
        else if (cmd.cur_next)
        begin
            cur_reg <= pred_q[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            chain_reg <= '0;
            lo_reg    <= '0;
            hi_reg    <= '0;
            ovf_reg   <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load || cmd.drop)
            begin
                last_reg <= in_last;
            end
            if (cmd.load)
            begin
                // position chain_reg stands for "above every tail"
                lo_reg <= '0;
                hi_reg <= chain_reg;
            end
            if (cmd.drop)
            begin
                ovf_reg <= 1'b1;
            end
            if (cmd.cmp_step)
            begin
                if (key_q >= key_reg)
                begin
                    hi_reg <= mid;
                end
                else
                begin
                    lo_reg <= mid + CNT_W'(1);
                end
            end
            if (cmd.update)
            begin
                count_reg <= count_reg + CNT_W'(1);
                if (lo_reg == chain_reg)
                begin
                    chain_reg <= chain_reg + CNT_W'(1);
                end
            end
            if (cmd.clear)
            begin
                count_reg <= '0;
                chain_reg <= '0;
                ovf_reg   <= 1'b0;
            end
        end
    end

    assign sts.full       = (count_reg == CNT_W'(MAX_ITEMS));
    assign sts.lo_lt_hi   = (lo_reg < hi_reg);
    assign sts.chain_zero = (chain_reg == '0);
    assign sts.last       = last_reg;
    assign sts.final_word = ~pred_q[IDX_W];

    assign item_index   = cur_reg;
    assign chosen_key   = key_q;
    assign final_result = ~pred_q[IDX_W];
    assign overflow     = ovf_reg;

endmodule
`default_nettype wire

[design/longest_increasing_chain.sv]
// Search: a key takes s search steps, s <= ceil(log2(chain length + 1));
//   a step is a range check, tail read, key read, compare.
// Flow: one key at a time; the walk after the last key gives the chain as
//   output words, and no key is taken until the chain is out.
// Reset: rst_n async active low clears counters, overflow flag and controller;
//   memories are not cleared, only entries written in the current set are read.
`default_nettype none
module longest_increasing_chain (
    input  wire logic  clk,
    input  wire logic  rst_n,
    lic_in_if.sink     in_ch,
    lic_out_if.source  out_ch
);
    import lic_pkg::*;

    lic_cmd_t cmd;
    lic_sts_t sts;

    // Controller sequences: accept, binary ceiling search over the tails
    // (lo..hi with hi = chain length meaning "append"), predecessor fetch,
    // table update, then on the last key a walk back along the links.
    lic_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_last   (in_ch.last_item),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Datapath holds the key store, tail table and link store, plus the
    // search bounds and set counters. Output word fields come straight
    // from its registers, so they stay put while the sink stalls.
    lic_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .in_key       (in_ch.key),
        .in_last      (in_ch.last_item),
        .item_index   (out_ch.item_index),
        .chosen_key   (out_ch.chosen_key),
        .final_result (out_ch.final_result),
        .overflow     (out_ch.overflow)
    );

endmodule
`default_nettype wire
